@@ sv/pct_pkg.sv @@
`default_nettype none

package pct_pkg;

	localparam int SET_CAPACITY_DEF = 16;
	localparam int ID_WIDTH_DEF     = 32;
	localparam int ID_PORT_W        = 32;
	localparam int MAX_RESULTS      = 16;
	localparam int EXIT_CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic OP_CONTACT   = 1'b0;
	localparam logic OP_FRAME_END = 1'b1;

	localparam logic EV_ENTERED = 1'b0;
	localparam logic EV_EXITED  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_C_SCAN,
		ST_C_DECIDE,
		ST_E_STEP,
		ST_E_EMIT
	} state_t;

endpackage

`default_nettype wire

@@ sv/presence_change_tracker.sv @@
// Presence change tracker.
// Input channel (in_valid/in_ready) takes one word: op selects a contact report
// (contact_id) or an end of frame. Output channel (out_valid/out_ready) gives
// entered/exited words; last_event marks the final word caused by one input.
// Ids of the previous and current frame sit in one RAM, one bank per frame,
// filled in slot order; a seen bit per previous-frame slot records that the id
// was also stored in the current frame.
// Contact: both banks are scanned one slot per cycle over the larger fill,
// then a decision step stores a new id and loads any event word.
// End of frame: previous-bank slots are walked in order; a slot with its seen
// bit set is skipped, a slot that exits is read from RAM, then output.
// The banks swap on the cycle after the walk ends.
// One input is worked on at a time; in_ready is high only between items. The
// output register holds a word until taken; stalls hold the decide/emit steps.
// Reset clears fill counts, seen bits, bank select and the output valid;
// RAM contents need no clearing, as fills bound every read.
`default_nettype none

module presence_change_tracker #(
	parameter int SET_CAPACITY = pct_pkg::SET_CAPACITY_DEF,
	parameter int ID_WIDTH     = pct_pkg::ID_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [pct_pkg::ID_PORT_W-1:0] contact_id,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               event_kind,
	output logic [pct_pkg::ID_PORT_W-1:0]      object_id,
	output logic                               not_stored,
	output logic                               last_event
);

	localparam int SW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam int FW = $clog2(SET_CAPACITY + 1);
	localparam int AW = SW + 1;
	localparam int CW = pct_pkg::EXIT_CNT_W;

	pct_pkg::state_t state_q, state_d;

	logic [ID_WIDTH-1:0] mem [2**AW];

	logic [ID_WIDTH-1:0]     id_in;
	logic [ID_WIDTH-1:0]     id_q;
	logic [FW-1:0]           scan_idx_q;
	logic [FW-1:0]           scan_len_q;
	logic [FW-1:0]           cur_fill_q;
	logic [FW-1:0]           prev_fill_q;
	logic                    cur_bank_q;
	logic [SET_CAPACITY-1:0] seen_q;
	logic                    found_prev_q;
	logic                    found_cur_q;
	logic [SW-1:0]           hit_slot_q;
	logic [CW-1:0]           exit_cnt_q;

	logic                    cmp_v_s1;
	logic [SW-1:0]           idx_s1;
	logic [ID_WIDTH-1:0]     rd_prev_s1;
	logic [ID_WIDTH-1:0]     rd_cur_s1;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic [ID_WIDTH-1:0]     out_id_q;
	logic                    out_drop_q;
	logic                    out_last_q;

	logic                    in_fire;
	logic                    out_free;
	logic [SW-1:0]           slot;
	logic                    rd_en;
	logic                    wr_en;
	logic                    load_out;
	logic                    c_go;
	logic                    c_store;
	logic                    c_drop;
	logic                    c_emit;
	logic                    e_done;
	logic                    e_last;
	logic [SET_CAPACITY-1:0] pend;
	logic [SET_CAPACITY-1:0] later;
	logic [SET_CAPACITY-1:0] fill_mask;

	for (genvar b = 0; b < ID_WIDTH; b++) begin : g_id_in
		if (b < pct_pkg::ID_PORT_W) begin : g_bit
			assign id_in[b] = contact_id[b];
		end else begin : g_zero
			assign id_in[b] = 1'b0;
		end
	end

	for (genvar b = 0; b < pct_pkg::ID_PORT_W; b++) begin : g_id_out
		if (b < ID_WIDTH) begin : g_bit
			assign object_id[b] = out_id_q[b];
		end else begin : g_zero
			assign object_id[b] = 1'b0;
		end
	end

	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign slot       = scan_idx_q[SW-1:0];
	assign out_valid  = out_valid_q;
	assign event_kind = out_kind_q;
	assign not_stored = out_drop_q;
	assign last_event = out_last_q;

	assign c_store = !found_cur_q && (cur_fill_q < FW'(SET_CAPACITY));
	assign c_drop  = !found_cur_q && !(cur_fill_q < FW'(SET_CAPACITY));
	assign c_emit  = !found_prev_q || c_drop;
	assign e_done  = (scan_idx_q == prev_fill_q) ||
		(exit_cnt_q == CW'(pct_pkg::MAX_RESULTS));

	always_comb begin
		for (int j = 0; j < SET_CAPACITY; j++) begin
			fill_mask[j] = FW'(j) < prev_fill_q;
			pend[j]      = !seen_q[j] && fill_mask[j];
			later[j]     = FW'(j) > scan_idx_q;
		end
		e_last = !(|(pend & later)) ||
			(exit_cnt_q == CW'(pct_pkg::MAX_RESULTS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pct_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = (op == pct_pkg::OP_FRAME_END) ? pct_pkg::ST_E_STEP
						: pct_pkg::ST_C_SCAN;
				end
			end
			pct_pkg::ST_C_SCAN: begin
				if (scan_idx_q == scan_len_q) begin
					state_d = pct_pkg::ST_C_DECIDE;
				end
			end
			pct_pkg::ST_C_DECIDE: begin
				if (c_go) begin
					state_d = pct_pkg::ST_IDLE;
				end
			end
			pct_pkg::ST_E_STEP: begin
				priority if (e_done) begin
					state_d = pct_pkg::ST_IDLE;
				end else if (pend[slot]) begin
					state_d = pct_pkg::ST_E_EMIT;
				end
			end
			pct_pkg::ST_E_EMIT: begin
				if (out_free) begin
					state_d = pct_pkg::ST_E_STEP;
				end
			end
			default: state_d = pct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		load_out = 1'b0;
		c_go     = 1'b0;
		unique case (state_q)
			pct_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pct_pkg::ST_C_SCAN: begin
				rd_en = scan_idx_q < scan_len_q;
			end
			pct_pkg::ST_C_DECIDE: begin
				c_go     = !c_emit || out_free;
				wr_en    = c_go && c_store;
				load_out = c_go && c_emit;
			end
			pct_pkg::ST_E_STEP: begin
				rd_en = !e_done && pend[slot];
			end
			pct_pkg::ST_E_EMIT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{cur_bank_q, cur_fill_q[SW-1:0]}] <= id_q;
		end
		if (rd_en) begin
			rd_prev_s1 <= mem[{~cur_bank_q, slot}];
			rd_cur_s1  <= mem[{cur_bank_q, slot}];
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_q <= id_in;
		end
		if (rd_en) begin
			idx_s1 <= slot;
		end
		if (cmp_v_s1 && (FW'(idx_s1) < prev_fill_q) && (rd_prev_s1 == id_q)) begin
			hit_slot_q <= idx_s1;
		end
		if (load_out) begin
			if (state_q == pct_pkg::ST_C_DECIDE) begin
				out_kind_q <= found_prev_q ? pct_pkg::EV_EXITED : pct_pkg::EV_ENTERED;
				out_id_q   <= id_q;
				out_drop_q <= c_drop;
				out_last_q <= 1'b1;
			end else begin
				out_kind_q <= pct_pkg::EV_EXITED;
				out_id_q   <= rd_prev_s1;
				out_drop_q <= 1'b0;
				out_last_q <= e_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pct_pkg::ST_IDLE;
			scan_idx_q   <= '0;
			scan_len_q   <= '0;
			cur_fill_q   <= '0;
			prev_fill_q  <= '0;
			cur_bank_q   <= 1'b0;
			seen_q       <= '0;
			found_prev_q <= 1'b0;
			found_cur_q  <= 1'b0;
			exit_cnt_q   <= '0;
			cmp_v_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= rd_en && (state_q == pct_pkg::ST_C_SCAN);

			if (in_fire) begin
				scan_idx_q   <= '0;
				scan_len_q   <= (prev_fill_q > cur_fill_q) ? prev_fill_q : cur_fill_q;
				found_prev_q <= 1'b0;
				found_cur_q  <= 1'b0;
				exit_cnt_q   <= '0;
			end

			if (state_q == pct_pkg::ST_C_SCAN && rd_en) begin
				scan_idx_q <= scan_idx_q + FW'(1);
			end

			if (cmp_v_s1) begin
				if ((FW'(idx_s1) < prev_fill_q) && (rd_prev_s1 == id_q)) begin
					found_prev_q <= 1'b1;
				end
				if ((FW'(idx_s1) < cur_fill_q) && (rd_cur_s1 == id_q)) begin
					found_cur_q <= 1'b1;
				end
			end

			if (state_q == pct_pkg::ST_C_DECIDE && c_go) begin
				if (c_store) begin
					cur_fill_q <= cur_fill_q + FW'(1);
				end
				if (found_prev_q && (found_cur_q || c_store)) begin
					seen_q[hit_slot_q] <= 1'b1;
				end
			end

			if (state_q == pct_pkg::ST_E_STEP) begin
				priority if (e_done) begin
					cur_bank_q  <= ~cur_bank_q;
					prev_fill_q <= cur_fill_q;
					cur_fill_q  <= '0;
					seen_q      <= '0;
				end else if (!pend[slot]) begin
					scan_idx_q <= scan_idx_q + FW'(1);
				end
			end

			if (state_q == pct_pkg::ST_E_EMIT && out_free) begin
				scan_idx_q <= scan_idx_q + FW'(1);
				exit_cnt_q <= exit_cnt_q + CW'(1);
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_fill_q <= FW'(SET_CAPACITY)) && (prev_fill_q <= FW'(SET_CAPACITY)))
		else $error("bank fill beyond capacity");

	a_swap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pct_pkg::ST_E_STEP && e_done) |=>
		(cur_fill_q == '0) && (seen_q == '0) && (cur_bank_q != $past(cur_bank_q)))
		else $error("frame end did not reset current bank");

	a_seen_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q & ~fill_mask) == '0)
		else $error("seen bit set beyond previous fill");

	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_drop_q) |-> out_last_q)
		else $error("drop notice not marked last");

	a_write_new: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (cur_fill_q == $past(cur_fill_q) + FW'(1)) && in_ready)
		else $error("store did not advance fill");

endmodule

`default_nettype wire

@@ dv/presence_change_tracker_tb.sv @@
`timescale 1ns / 100ps

module presence_change_tracker_tb;

	localparam int CAP          = pct_pkg::SET_CAPACITY_DEF;
	localparam int SETTLE_CYC   = 48;
	localparam int RAND_PER_PH  = 125;
	localparam int POOL_SZ      = 24;

	typedef struct packed {
		logic                          kind;
		logic [pct_pkg::ID_PORT_W-1:0] id;
		logic                          dropped;
		logic                          last;
	} presence_ev_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          op;
	logic [pct_pkg::ID_PORT_W-1:0] contact_id;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          event_kind;
	logic [pct_pkg::ID_PORT_W-1:0] object_id;
	logic                          not_stored;
	logic                          last_event;

	// predictor state
	logic [pct_pkg::ID_PORT_W-1:0] bank_ids  [2][CAP];
	bit                            bank_live [2][CAP];
	bit                            cur_bank;
	int                            cur_fill;

	presence_ev_t                  pending_events[$];
	logic [pct_pkg::ID_PORT_W-1:0] id_pool[POOL_SZ];
	int                            fail_cnt    = 0;
	int                            words_sent  = 0;
	int                            tx_idle_pct = 0;
	int                            rx_stall_pct = 0;

	presence_change_tracker u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.contact_id (contact_id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.object_id  (object_id),
		.not_stored (not_stored),
		.last_event (last_event)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic bit bank_has(input bit b, input logic [pct_pkg::ID_PORT_W-1:0] id);
		for (int i = 0; i < CAP; i++) begin
			if (bank_live[b][i] && bank_ids[b][i] == id)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_word(input logic p_op, input logic [pct_pkg::ID_PORT_W-1:0] p_id);
		bit           prv;
		bit           entered;
		bit           dropped;
		presence_ev_t ev;
		presence_ev_t exits[$];
		prv = ~cur_bank;
		if (p_op == pct_pkg::OP_CONTACT) begin
			entered = !bank_has(prv, p_id);
			dropped = 1'b0;
			if (!bank_has(cur_bank, p_id)) begin
				if (cur_fill < CAP) begin
					bank_ids[cur_bank][cur_fill]  = p_id;
					bank_live[cur_bank][cur_fill] = 1'b1;
					cur_fill++;
				end else begin
					dropped = 1'b1;
				end
			end
			// drop notice: known id that no longer fits reports as exited + not_stored
			if (entered || dropped) begin
				ev.kind    = entered ? pct_pkg::EV_ENTERED : pct_pkg::EV_EXITED;
				ev.id      = p_id;
				ev.dropped = dropped;
				ev.last    = 1'b1;
				pending_events.push_back(ev);
			end
		end else begin
			for (int i = 0; i < CAP; i++) begin
				if (bank_live[prv][i] && exits.size() < pct_pkg::MAX_RESULTS &&
						!bank_has(cur_bank, bank_ids[prv][i])) begin
					ev.kind    = pct_pkg::EV_EXITED;
					ev.id      = bank_ids[prv][i];
					ev.dropped = 1'b0;
					ev.last    = 1'b0;
					exits.push_back(ev);
				end
			end
			if (exits.size() > 0)
				exits[exits.size()-1].last = 1'b1;
			foreach (exits[k])
				pending_events.push_back(exits[k]);
			for (int i = 0; i < CAP; i++)
				bank_live[prv][i] = 1'b0;
			cur_bank = prv;
			cur_fill = 0;
		end
	endtask

	always @(posedge clk) begin : word_check
		presence_ev_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected word: event_kind %0b object_id %h not_stored %0b last_event %0b",
					event_kind, object_id, not_stored, last_event);
				fail_cnt++;
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind mismatch: expected %0b, actual %0b", want.kind, event_kind);
					fail_cnt++;
				end
				if (object_id !== want.id) begin
					$error("object_id mismatch: expected %h, actual %h", want.id, object_id);
					fail_cnt++;
				end
				if (not_stored !== want.dropped) begin
					$error("not_stored mismatch: expected %0b, actual %0b", want.dropped, not_stored);
					fail_cnt++;
				end
				if (last_event !== want.last) begin
					$error("last_event mismatch: expected %0b, actual %0b", want.last, last_event);
					fail_cnt++;
				end
			end
		end
	end

	task automatic send_word(input logic w_op, input logic [pct_pkg::ID_PORT_W-1:0] w_id);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= w_op;
		contact_id <= w_id;
		do @(posedge clk); while (!in_ready);
		predict_word(w_op, w_id);
		words_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic test_entries_and_duplicates();
		send_word(pct_pkg::OP_CONTACT, 32'h0000_0000);
		send_word(pct_pkg::OP_CONTACT, 32'hFFFF_FFFF);
		send_word(pct_pkg::OP_CONTACT, 32'h0000_0000);
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		// known id stays: nothing to report
		send_word(pct_pkg::OP_CONTACT, 32'hFFFF_FFFF);
		wait_idle();
	endtask

	task automatic test_exits_and_empty_frames();
		send_word(pct_pkg::OP_FRAME_END, 32'hA5A5_5A5A);
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		wait_idle();
	endtask

	task automatic test_full_bank();
		send_word(pct_pkg::OP_CONTACT, 32'h8000_0001);
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		for (int i = 0; i < CAP; i++)
			send_word(pct_pkg::OP_CONTACT, 32'h1000_0000 + i * 32'h0101_0101);
		send_word(pct_pkg::OP_CONTACT, 32'h8000_0001);
		send_word(pct_pkg::OP_CONTACT, 32'h7FFF_FFFE);
		send_word(pct_pkg::OP_CONTACT, 32'h1000_0000);
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		// full previous bank, nothing carried over: maximum exit burst
		send_word(pct_pkg::OP_FRAME_END, 32'h0);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int target;
		int n;
		int reach;
		tx_idle_pct  = idle_pct;
		rx_stall_pct = stall_pct;
		target = words_sent + RAND_PER_PH;
		foreach (id_pool[i])
			id_pool[i] = $urandom;
		while (words_sent < target) begin
			n     = ($urandom_range(99) < 25) ? $urandom_range(14, 22) : $urandom_range(0, 8);
			reach = $urandom_range(4, POOL_SZ);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(99) < 85)
					send_word(pct_pkg::OP_CONTACT, id_pool[$urandom_range(reach - 1)]);
				else
					send_word(pct_pkg::OP_CONTACT, $urandom);
			end
			send_word(pct_pkg::OP_FRAME_END, $urandom);
			if ($urandom_range(99) < 8)
				send_word(pct_pkg::OP_FRAME_END, $urandom);
		end
		wait_idle();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		op         = pct_pkg::OP_CONTACT;
		contact_id = '0;
		cur_bank   = 1'b0;
		cur_fill   = 0;
		foreach (bank_live[b, i])
			bank_live[b][i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_entries_and_duplicates();
		test_exits_and_empty_frames();
		test_full_bank();
		test_random_traffic(0, 0);
		test_random_traffic(66, 0);
		test_random_traffic(0, 66);
		test_random_traffic(17, 17);

		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ sim.f @@
sv/pct_pkg.sv
sv/presence_change_tracker.sv
dv/presence_change_tracker_tb.sv
